[rtl/mlrt_pkg.sv]
// shared constants and types for the multichannel linear ramp table
`default_nettype none
package mlrt_pkg;

  localparam int unsigned NumChannelsDefault = 16;

  localparam int unsigned CH_W     = 4;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TICK_W   = 20;
  localparam int unsigned MAG_W    = VAL_W + 1;
  localparam int unsigned CH_EXT_W = 7;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0]  from_value;
    logic [VAL_W-1:0]  to_value;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] elapsed;
  } ramp_entry_t;

endpackage
`default_nettype wire

[rtl/multichannel_linear_ramp_table.sv]
// multichannel linear ramp table: channel memory, tick walker and output register
//
//   channel  dir  tdata (low bit up)                              tuser      tlast
//   s_axis   in   channel, from_value, to_value, duration, tick   kind       -
//   m_axis   out  out_channel, value, zero pad                    done_res   last
//
// a start item goes via the emit state to the output register; a tick walks every channel
// one per cycle, sending each active one not at its end through the shared multiply-divide
// unit (2 multiply steps, 33 divide steps). reset clears the active flags and control state;
// the channel memory needs no clearing. a stalled output holds its item and the walker waits.
`default_nettype none
module multichannel_linear_ramp_table
  import mlrt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // channel, from_value, to_value, duration, tick_time
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_channel, value, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // done_res
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  ramp_entry_t mem [NUM_CHANNELS];
  ramp_entry_t rd_q;

  logic [2:0]              state_q;
  logic [CNT_W-1:0]        c_q;
  logic [NUM_CHANNELS-1:0] act_q, snap_q;
  logic [TICK_W-1:0]       tick_q;
  logic                    is_tick_q, neg_q;

  logic [CH_W-1:0]  res_ch_q;
  logic [VAL_W-1:0] res_val_q;
  logic             res_done_q, res_last_q;

  logic             out_valid_q;
  logic [CH_W-1:0]  out_ch_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_done_q, out_last_q;

  // input unpack
  logic [CH_W-1:0]     in_ch;
  logic [CH_EXT_W-1:0] in_ch_ext;
  logic [VAL_W-1:0]    in_from, in_to;
  logic [TIME_W-1:0]   in_dur;
  logic [TICK_W-1:0]   in_tick;
  logic                in_fire;

  assign in_ch     = s_axis_tdata[3:0];
  assign in_from   = s_axis_tdata[35:4];
  assign in_to     = s_axis_tdata[67:36];
  assign in_dur    = s_axis_tdata[99:68];
  assign in_tick   = s_axis_tdata[119:100];
  assign in_ch_ext = CH_EXT_W'(in_ch);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  logic [IDX_W-1:0] idx;
  assign idx = c_q[IDX_W-1:0];

  // per-channel update from the entry just read
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] el_new;
  logic              fin;
  logic [MAG_W-1:0]  diff, mag;
  logic              more;

  always_comb begin
    sum    = {1'b0, rd_q.elapsed} + {13'b0, tick_q};
    el_new = (sum > {1'b0, rd_q.duration}) ? rd_q.duration : sum[TIME_W-1:0];
    fin    = el_new >= rd_q.duration;
    diff   = {rd_q.to_value[VAL_W-1], rd_q.to_value}
           - {rd_q.from_value[VAL_W-1], rd_q.from_value};
    mag    = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
    more   = 1'b0;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if (snap_q[j] && (j > int'(c_q))) more = 1'b1;
    end
  end

  logic             md_start, md_done;
  logic [VAL_W-1:0] md_quot;

  assign md_start = (state_q == ST_RD) && !fin;

  mlrt_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mag_i   (mag),
    .el_i    (el_new),
    .dur_i   (rd_q.duration),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  logic out_load;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // memory: one write port, registered read
  ramp_entry_t wr_d;
  logic        we;
  logic [IDX_W-1:0] wa;

  always_comb begin
    we   = 1'b0;
    wa   = idx;
    wr_d = rd_q;
    wr_d.elapsed = el_new;
    if (in_fire && s_axis_tuser == KIND_START
        && in_ch_ext < CH_EXT_W'(NUM_CHANNELS)) begin
      we   = 1'b1;
      wa   = in_ch_ext[IDX_W-1:0];
      wr_d = '{from_value: in_from, to_value: in_to, duration: in_dur, elapsed: '0};
    end else if (state_q == ST_RD) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wr_d;
    if (state_q == ST_SCAN) rd_q <= mem[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      act_q       <= '0;
      snap_q      <= '0;
      is_tick_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == KIND_TICK) begin
              is_tick_q <= 1'b1;
              snap_q    <= act_q;
              c_q       <= '0;
              state_q   <= ST_SCAN;
            end else if (in_ch_ext < CH_EXT_W'(NUM_CHANNELS)) begin
              is_tick_q <= 1'b0;
              act_q[in_ch_ext[IDX_W-1:0]] <= 1'b1;
              state_q   <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          if (c_q == CNT_W'(NUM_CHANNELS)) state_q <= ST_IDLE;
          else if (snap_q[idx]) state_q <= ST_RD;
          else c_q <= c_q + CNT_W'(1);
        end
        ST_RD: begin
          if (fin) begin
            act_q[idx] <= 1'b0;
            state_q    <= ST_EMIT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (md_done) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            if (is_tick_q) begin
              c_q     <= c_q + CNT_W'(1);
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) tick_q <= in_tick;
    if (state_q == ST_IDLE) begin
      res_ch_q   <= in_ch;
      res_val_q  <= in_from;
      res_done_q <= 1'b0;
      res_last_q <= 1'b1;
    end
    if (state_q == ST_RD) begin
      res_ch_q   <= CH_W'(c_q);
      res_val_q  <= rd_q.to_value;
      res_done_q <= fin;
      res_last_q <= !more;
      neg_q      <= diff[MAG_W-1];
    end
    if (state_q == ST_DIV && md_done) begin
      // truncation toward the start value
      res_val_q <= neg_q ? (rd_q.from_value - md_quot) : (rd_q.from_value + md_quot);
    end
    if (out_load) begin
      out_ch_q   <= res_ch_q;
      out_val_q  <= res_val_q;
      out_done_q <= res_done_q;
      out_last_q <= res_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_val_q, out_ch_q};
  assign m_axis_tuser  = out_done_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

[rtl/mlrt_muldiv.sv]
// computes mag * el / dur with a two-step multiply and a bit-serial divide
`default_nettype none
module mlrt_muldiv
  import mlrt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [MAG_W-1:0]  mag_i,
  input  wire logic [TIME_W-1:0] el_i,
  input  wire logic [TIME_W-1:0] dur_i,
  output logic                   done_o,
  output logic [VAL_W-1:0]       quot_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam int unsigned PW = MAG_W + TIME_W;  // 65
  localparam int unsigned HW = MAG_W + 16;      // 49

  logic [1:0]        ph_q;
  logic [5:0]        cnt_q;
  logic [HW-1:0]     prod_q;
  logic [MAG_W-1:0]  mag_q;
  logic [15:0]       el_hi_q;
  logic [TIME_W-1:0] dur_q;
  logic [TIME_W-1:0] rem_q;
  logic [MAG_W-1:0]  lo_q;
  logic [MAG_W-1:0]  quot_q;
  logic              done_q;

  logic [HW-1:0] p0, p1;
  logic [PW-1:0] full;
  logic [TIME_W:0] r2, r2_sub;
  logic          ge;

  always_comb begin
    p0     = {16'b0, mag_i} * {33'b0, el_i[15:0]};
    p1     = {16'b0, mag_q} * {33'b0, el_hi_q};
    full   = {16'b0, prod_q} + {p1, 16'b0};
    r2     = {rem_q, lo_q[MAG_W-1]};
    ge     = r2 >= {1'b0, dur_q};
    r2_sub = r2 - {1'b0, dur_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        PH_IDLE: begin
          if (start_i) ph_q <= PH_MUL;
        end
        PH_MUL: begin
          cnt_q <= 6'(MAG_W);
          ph_q  <= PH_DIV;
        end
        PH_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            ph_q   <= PH_IDLE;
            done_q <= 1'b1;
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        prod_q  <= p0;
        mag_q   <= mag_i;
        el_hi_q <= el_i[31:16];
        dur_q   <= dur_i;
      end
      PH_MUL: begin
        // top bits of the product are below dur, so they seed the remainder
        rem_q  <= full[PW-1:MAG_W];
        lo_q   <= full[MAG_W-1:0];
        quot_q <= '0;
      end
      PH_DIV: begin
        rem_q  <= ge ? r2_sub[TIME_W-1:0] : r2[TIME_W-1:0];
        lo_q   <= {lo_q[MAG_W-2:0], 1'b0};
        quot_q <= {quot_q[MAG_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q[VAL_W-1:0];

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// testbench for the multichannel linear ramp table: random start and tick items, checked results
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
  logic [3:0]  ch;
  logic [31:0] value;
  logic        done;
  logic        last;
} ramp_result_t;

class ramp_scoreboard;
  bit          busy[16];
  logic [31:0] from_v[16];
  logic [31:0] to_v[16];
  logic [31:0] dur_v[16];
  logic [31:0] elapsed_v[16];
  ramp_result_t pending_results[$];
  int errors;
  int checked;

  function automatic logic [31:0] lerp(logic [31:0] f, logic [31:0] t, logic [31:0] el,
                                       logic [31:0] dur);
    longint fs;
    longint ts;
    longint diff;
    longint unsigned mag;
    longint unsigned q;
    fs = longint'(signed'(f));
    ts = longint'(signed'(t));
    diff = ts - fs;
    mag = (diff < 0) ? longint'(-diff) : diff;
    q = (mag * el) / dur;
    return (diff < 0) ? 32'(fs - longint'(q)) : 32'(fs + longint'(q));
  endfunction

  function automatic void note_item(logic kind, logic [3:0] ch, logic [31:0] f,
                                    logic [31:0] t, logic [31:0] dur, logic [19:0] tick);
    ramp_result_t r;
    longint unsigned sum;
    int first;
    if (kind == mlrt_pkg::KIND_START) begin
      from_v[ch] = f;
      to_v[ch] = t;
      dur_v[ch] = dur;
      elapsed_v[ch] = '0;
      busy[ch] = 1'b1;
      r = '{ch: ch, value: f, done: 1'b0, last: 1'b1};
      pending_results.push_back(r);
      return;
    end
    first = pending_results.size();
    for (int c = 0; c < 16; c++) begin
      if (busy[c]) begin
        sum = longint'(elapsed_v[c]) + tick;
        if (sum > dur_v[c]) sum = dur_v[c];
        elapsed_v[c] = 32'(sum);
        if (elapsed_v[c] >= dur_v[c]) begin
          r = '{ch: 4'(c), value: to_v[c], done: 1'b1, last: 1'b0};
          busy[c] = 1'b0;
        end else begin
          r = '{ch: 4'(c), value: lerp(from_v[c], to_v[c], elapsed_v[c], dur_v[c]),
                done: 1'b0, last: 1'b0};
        end
        pending_results.push_back(r);
      end
    end
    if (pending_results.size() > first)
      pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  function automatic void check_result(logic [3:0] ch, logic [31:0] value, logic done,
                                       logic last);
    ramp_result_t e;
    checked++;
    if (pending_results.size() == 0) begin
      $error("unexpected result ch=%0d value=%h", ch, value);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (ch !== e.ch) begin
      $error("out_channel: expected %0d actual %0d", e.ch, ch); errors++;
    end
    if (value !== e.value) begin
      $error("value: expected %h actual %h", e.value, value); errors++;
    end
    if (done !== e.done) begin
      $error("done_res: expected %0d actual %0d", e.done, done); errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d actual %0d", e.last, last); errors++;
    end
  endfunction
endclass

module tb_top;
  import mlrt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  ramp_scoreboard ramps = new();
  int n_starts;
  int n_ticks;
  bit stall_off;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  multichannel_linear_ramp_table dut (.*);

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, checks each accepted result
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      ramps.check_result(m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tuser, m_axis_tlast);
    if (rst_ni) m_axis_tready <= stall_off ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // valid drops only when a gap follows, so back to back items keep it high
  task automatic send_item(logic kind, logic [3:0] ch, logic [31:0] f, logic [31:0] t,
                           logic [31:0] dur, logic [19:0] tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {tick, dur, t, f, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ramps.note_item(kind, ch, f, t, dur, tick);
    if (kind == KIND_START) n_starts++; else n_ticks++;
  endtask

  task automatic start_ramp(logic [3:0] ch, logic [31:0] f, logic [31:0] t, logic [31:0] dur);
    send_item(KIND_START, ch, f, t, dur, 20'($urandom));
  endtask

  task automatic tick(logic [19:0] tt);
    send_item(KIND_TICK, 4'($urandom), $urandom, $urandom, $urandom, tt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (ramps.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_dur();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 50);
      2: return $urandom;
      default: return $urandom_range(1, 3000000);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, zero duration, restart, empty tick
    tick(20'hFFFFF);
    start_ramp(4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1000);
    start_ramp(4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    start_ramp(4'd3, 32'h0001_0000, 32'hFFFF_0000, 32'd0);
    start_ramp(4'd5, 32'h0, 32'h0, 32'd7);
    tick(20'd0);
    tick(20'd1);
    start_ramp(4'd0, 32'hFFFF_FFFF, 32'h0, 32'd3);
    tick(20'd999);
    tick(20'hFFFFF);
    for (int c = 0; c < 16; c++)
      start_ramp(4'(c), $urandom, $urandom, $urandom_range(0, 2000000));
    tick(20'd500000);
    stall_off = 1'b1;
    drain();
    tick(20'hFFFFF);
    stall_off = 1'b0;
    tick(20'hFFFFF);
    for (int i = 0; i < 4; i++) tick(20'hFFFFF);
    // random: mostly starts, ticks sized to reach the ramp ends
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 9) < 6)
        start_ramp(4'($urandom), $urandom, $urandom, rand_dur());
      else
        tick(($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 400000)));
      if (i == 75) drain();
    end
    drain();
    repeat (1200) @(posedge clk_i);
    $display("covered %0d start items and %0d tick items, %0d results compared",
             n_starts, n_ticks, ramps.checked);
    if (ramps.errors == 0 && ramps.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/mlrt_pkg.sv
rtl/mlrt_muldiv.sv
rtl/multichannel_linear_ramp_table.sv
tb/sv/tb_top.sv
